>>> src/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Fixed field widths, register map, state encoding and the control and
// status words between the top level and the serial arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

	// Default parameter values.
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	// Field widths fixed by the Q16.8 formats.
	localparam int EST_W   = 24;
	localparam int COV_W   = 24;
	localparam int NOISE_W = 24;
	localparam int PM_W    = 25;
	localparam int DEN_W   = 26;

	// Estimate saturation limits.
	localparam logic [EST_W-1:0] EST_MAX = 24'h7FFFFF;
	localparam logic [EST_W-1:0] EST_MIN = 24'h800000;

	// Register map: the register index is the address bit above the byte lanes.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_PROCESS_NOISE = 1'b0;
	localparam logic REG_MEASURE_NOISE = 1'b1;
	localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 24'd5120;
	localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 24'd51200;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_ROUND,
		ST_WRITE
	} state_t;

	// Control word to the serial unit.
	typedef struct packed {
		logic start;
		logic gate;
	} serial_ctl_t;

	// Status word from the serial unit.
	typedef struct packed {
		logic busy;
		logic done;
	} serial_sts_t;

endpackage

`default_nettype wire

>>> src/skf_serial_unit.sv
// ----------------------------------------------------------------------------
// skf_serial_unit: bit-serial gain division with fused multiplies
// Restoring division of Pm * 2^G by Pm + R yields one gain bit per cycle,
// most significant first; each gain bit is folded at once into the two
// MSB-first shift-add products k * |d| and k * Pm.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_serial_unit #(
	parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF,
	parameter int DMAG_W         = skf_pkg::EST_W
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire skf_pkg::serial_ctl_t                   ctl,
	input  wire logic [skf_pkg::PM_W-1:0]               pm,
	input  wire logic [skf_pkg::DEN_W-1:0]              den,
	input  wire logic [DMAG_W-1:0]                      dmag,
	output skf_pkg::serial_sts_t                        sts,
	output logic [DMAG_W+GAIN_FRAC_BITS:0]              acc_e,
	output logic [skf_pkg::PM_W+GAIN_FRAC_BITS:0]       acc_p
);

	localparam int G     = GAIN_FRAC_BITS;
	localparam int REM_W = skf_pkg::DEN_W + 1;
	localparam int AE_W  = DMAG_W + G + 1;
	localparam int AP_W  = skf_pkg::PM_W + G + 1;
	localparam int CNT_W = $clog2(G + 2);

	logic [REM_W-1:0] rem_q;
	logic [AE_W-1:0]  acc_e_q;
	logic [AP_W-1:0]  acc_p_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             gate_q;

	logic [REM_W:0]   trial;
	logic             qbit;
	logic [REM_W-1:0] rem_next;

	// Trial subtraction decides one gain bit.
	assign trial    = {1'b0, rem_q} - {2'b00, den};
	assign qbit     = !trial[REM_W] && !gate_q;
	assign rem_next = qbit ? trial[REM_W-1:0] : rem_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			gate_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(G + 1);
				gate_q <= ctl.gate;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and product accumulators.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q   <= {{(REM_W-skf_pkg::PM_W){1'b0}}, pm};
			acc_e_q <= '0;
			acc_p_q <= '0;
		end else if (busy_q) begin
			rem_q   <= {rem_next[REM_W-2:0], 1'b0};
			acc_e_q <= {acc_e_q[AE_W-2:0], 1'b0}
				+ {{(G+1){1'b0}}, dmag & {DMAG_W{qbit}}};
			acc_p_q <= {acc_p_q[AP_W-2:0], 1'b0}
				+ {{(G+1){1'b0}}, pm & {skf_pkg::PM_W{qbit}}};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign acc_e    = acc_e_q;
	assign acc_p    = acc_p_q;

endmodule

`default_nettype wire

>>> src/scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit: one-dimensional Kalman filter, fixed point
// Filters a stream of signed integer samples into signed Q16.8 estimates
// with unit transition and observation gains.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on sample/sample_valid/sample_ready, one word at a time;
//   each yields one estimate word on estimate/estimate_valid/estimate_ready.
//   The noise registers Q (address 0) and R (address 4) are written over the
//   APB port; pready is always high. The user must write them only while the
//   filter is idle; the block itself does not enforce it.
// Sequence:
//   A sample is taken only in the idle state. The serial unit is then loaded
//   and makes one gain bit a cycle, folded into both products at once; the
//   result is rounded and written, and the sequencer returns to idle.
// Reset:
//   Estimate and covariance clear to zero, Q and R load their defaults and
//   the output word is invalid.
// Stall:
//   The output register holds a finished estimate while the receiver stalls,
//   and the next sample is still taken and worked on; it waits only at its
//   final write until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_unit #(
	parameter int SAMPLE_BITS    = skf_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration port
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [skf_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [skf_pkg::DATA_W-1:0]           pwdata,
	output logic      [skf_pkg::DATA_W-1:0]           prdata,
	output logic                                      pready,
	// Sample channel
	input  wire logic                                 sample_valid,
	output logic                                      sample_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample,
	// Estimate channel
	output logic                                      estimate_valid,
	input  wire logic                                 estimate_ready,
	output logic signed [skf_pkg::EST_W-1:0]          estimate
);

	localparam int G      = GAIN_FRAC_BITS;
	localparam int EST_W  = skf_pkg::EST_W;
	localparam int PM_W   = skf_pkg::PM_W;
	localparam int DEN_W  = skf_pkg::DEN_W;
	localparam int COV_W  = skf_pkg::COV_W;
	localparam int M_W    = (SAMPLE_BITS + 8 > EST_W) ? SAMPLE_BITS + 8 : EST_W;
	localparam int DIFF_W = M_W + 1;
	localparam int DMAG_W = M_W;
	localparam int AE_W   = DMAG_W + G + 1;
	localparam int AP_W   = PM_W + G + 1;
	localparam int RND_W  = DMAG_W + 2;
	localparam int XS_W   = DMAG_W + 4;

	localparam logic [AE_W:0]   HALF_E = (AE_W+1)'(1) << (G - 1);
	localparam logic [AP_W-1:0] HALF_P = AP_W'(1) << (G - 1);

	skf_pkg::state_t      state_q, state_d;
	skf_pkg::serial_ctl_t ctl;
	skf_pkg::serial_sts_t sts;

	logic [skf_pkg::NOISE_W-1:0] q_noise_q, r_noise_q;
	logic [EST_W-1:0]            est_q;
	logic [COV_W-1:0]            cov_q;
	logic [PM_W-1:0]             pm_q;
	logic [DEN_W-1:0]            den_q;
	logic [DMAG_W-1:0]           dmag_q;
	logic                        neg_q;
	logic                        gate_q;
	logic [RND_W-1:0]            rnd_q;
	logic [COV_W-1:0]            cov_next_q;
	logic [EST_W-1:0]            estimate_q;
	logic                        estimate_valid_q;

	logic                        sample_fire;
	logic                        write_en;
	logic                        cfg_write;
	logic [PM_W-1:0]             pm_d;
	logic [DEN_W-1:0]            den_d;
	logic [DIFF_W-1:0]           diff_d;
	logic [DIFF_W-1:0]           mag_d;
	logic [AE_W-1:0]             acc_e;
	logic [AP_W-1:0]             acc_p;
	logic [AE_W:0]               sum_e;
	logic [AP_W-1:0]             sum_p;
	logic [PM_W:0]               p_full;
	logic [XS_W-1:0]             rnd_ext;
	logic [XS_W-1:0]             x_sum;
	logic [EST_W-1:0]            x_sat;

	// Configuration registers and read data.
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= skf_pkg::PROCESS_NOISE_RST;
			r_noise_q <= skf_pkg::MEASURE_NOISE_RST;
		end else if (cfg_write) begin
			unique case (paddr[skf_pkg::ADDR_W-1])
				skf_pkg::REG_PROCESS_NOISE: q_noise_q <= pwdata[skf_pkg::NOISE_W-1:0];
				skf_pkg::REG_MEASURE_NOISE: r_noise_q <= pwdata[skf_pkg::NOISE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[skf_pkg::ADDR_W-1])
			skf_pkg::REG_PROCESS_NOISE:
				prdata = {{(skf_pkg::DATA_W-skf_pkg::NOISE_W){1'b0}}, q_noise_q};
			skf_pkg::REG_MEASURE_NOISE:
				prdata = {{(skf_pkg::DATA_W-skf_pkg::NOISE_W){1'b0}}, r_noise_q};
			default:
				prdata = '0;
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and controls.
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		ctl.start    = 1'b0;
		ctl.gate     = gate_q;
		write_en     = 1'b0;
		unique case (state_q)
			skf_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					state_d = skf_pkg::ST_LOAD;
				end
			end
			skf_pkg::ST_LOAD: begin
				ctl.start = 1'b1;
				state_d   = skf_pkg::ST_RUN;
			end
			skf_pkg::ST_RUN: begin
				if (sts.done) begin
					state_d = skf_pkg::ST_ROUND;
				end
			end
			skf_pkg::ST_ROUND: begin
				state_d = skf_pkg::ST_WRITE;
			end
			skf_pkg::ST_WRITE: begin
				if (!estimate_valid_q || estimate_ready) begin
					write_en = 1'b1;
					state_d  = skf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skf_pkg::ST_IDLE;
			end
		endcase
	end

	assign sample_fire = sample_valid && sample_ready;

	// Predicted covariance, gain denominator and innovation at acceptance.
	assign pm_d   = {1'b0, cov_q} + {1'b0, q_noise_q};
	assign den_d  = {1'b0, pm_d} + {2'b00, r_noise_q};
	assign diff_d = {{(DIFF_W-SAMPLE_BITS-8){sample[SAMPLE_BITS-1]}}, sample, 8'h00}
		- {{(DIFF_W-EST_W){est_q[EST_W-1]}}, est_q};
	assign mag_d  = diff_d[DIFF_W-1] ? (DIFF_W'(0) - diff_d) : diff_d;

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			pm_q   <= pm_d;
			den_q  <= den_d;
			dmag_q <= mag_d[DMAG_W-1:0];
			neg_q  <= diff_d[DIFF_W-1];
			gate_q <= (den_d == '0);
		end
	end

	skf_serial_unit #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.DMAG_W         (DMAG_W)
	) u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pm     (pm_q),
		.den    (den_q),
		.dmag   (dmag_q),
		.sts    (sts),
		.acc_e  (acc_e),
		.acc_p  (acc_p)
	);

	// Rounding of both products; halves round away from zero on the magnitude.
	assign sum_e  = {1'b0, acc_e} + HALF_E;
	assign sum_p  = {1'b0, pm_q, {G{1'b0}}} - acc_p + HALF_P;
	assign p_full = sum_p[AP_W-1:G];

	always_ff @(posedge clk) begin
		if (state_q == skf_pkg::ST_ROUND) begin
			rnd_q      <= sum_e[AE_W:G];
			cov_next_q <= (|p_full[PM_W:COV_W]) ? {COV_W{1'b1}} : p_full[COV_W-1:0];
		end
	end

	// Estimate update with saturation.
	assign rnd_ext = {{(XS_W-RND_W){1'b0}}, rnd_q};
	assign x_sum   = {{(XS_W-EST_W){est_q[EST_W-1]}}, est_q}
		+ (neg_q ? (XS_W'(0) - rnd_ext) : rnd_ext);

	always_comb begin
		if ((&x_sum[XS_W-1:EST_W-1]) || !(|x_sum[XS_W-1:EST_W-1])) begin
			x_sat = x_sum[EST_W-1:0];
		end else if (x_sum[XS_W-1]) begin
			x_sat = skf_pkg::EST_MIN;
		end else begin
			x_sat = skf_pkg::EST_MAX;
		end
	end

	// Filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			cov_q <= '0;
		end else if (write_en) begin
			est_q <= x_sat;
			cov_q <= cov_next_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estimate_valid_q <= 1'b0;
		end else if (write_en) begin
			estimate_valid_q <= 1'b1;
		end else if (estimate_ready) begin
			estimate_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			estimate_q <= x_sat;
		end
	end

	assign estimate_valid = estimate_valid_q;
	assign estimate       = estimate_q;

	// A sample is only taken while the serial unit is free.
	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> !sts.busy)
		else $error("sample taken while the serial unit is busy");

	// The serial unit reports completion only while the sequencer waits for it.
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == skf_pkg::ST_RUN)
		else $error("serial completion outside the run state");

	// A start always sets the serial unit running.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skf_pkg::ST_LOAD |=> sts.busy)
		else $error("serial unit failed to start");

	// A finished update shows up in the output register and the state.
	a_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		write_en |=> estimate_valid && estimate == $past(x_sat) && est_q == $past(x_sat))
		else $error("estimate update lost");

endmodule

`default_nettype wire
